@@ hw/rtl/rzx3_pkg.sv @@
// ----------------------------------------------------------------------------
// rzx3_pkg
// Shared types, constants and helpers for the rgb555 3x zoom core.
// ----------------------------------------------------------------------------
package rzx3_pkg;

  localparam int unsigned CH_W  = 5;
  localparam int unsigned PIX_W = 16;
  localparam int unsigned SUM_W = 7;   // holds 2*31+31 and 31+31+31

  localparam logic [CH_W-1:0] GREY_BIAS = 5'd3;
  localparam logic [CH_W-1:0] GREY_MAX  = 5'd31;
  localparam logic            TOP_BIT   = 1'b1;

  // reciprocal of 3 as 43/128, exact for values below 128
  localparam logic [5:0] RECIP3     = 6'd43;
  localparam int unsigned RECIP3_SH = 7;

  // channel order matches the rgb555 word: red in the low bits
  typedef struct packed {
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
  } rgb5_t;

  localparam rgb5_t DIV_COLOR = '{b: 5'd15, g: 5'd10, r: 5'd5};

  // advance enables of the later pipeline stages
  typedef struct packed {
    logic en2;
    logic en3;
  } stage_en_t;

  function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [SUM_W+5:0] prod;
    prod = {6'd0, x} * {{SUM_W{1'b0}}, RECIP3};
    return prod[RECIP3_SH +: CH_W];
  endfunction

  function automatic logic [PIX_W-1:0] pack5(input rgb5_t c);
    return {TOP_BIT, c};
  endfunction

endpackage

@@ hw/rtl/rzx3_in_if.sv @@
// ----------------------------------------------------------------------------
// rzx3_in_if
// Input channel: source pixel, its three neighbours and mode flags.
// ----------------------------------------------------------------------------
interface rzx3_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] src_pixel;
  logic [15:0] right_pixel;
  logic [15:0] below_pixel;
  logic [15:0] diag_pixel;
  logic        right_present;
  logic        below_present;
  logic        interp_mode;
  logic        divider_mark;

  modport source (
    output valid, src_pixel, right_pixel, below_pixel, diag_pixel,
           right_present, below_present, interp_mode, divider_mark,
    input  ready
  );
  modport sink (
    input  valid, src_pixel, right_pixel, below_pixel, diag_pixel,
           right_present, below_present, interp_mode, divider_mark,
    output ready
  );
endinterface

@@ hw/rtl/rzx3_out_if.sv @@
// ----------------------------------------------------------------------------
// rzx3_out_if
// Result channel: the nine zoomed pixels and the tinted grey pixel.
// ----------------------------------------------------------------------------
interface rzx3_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] blk_r0c0;
  logic [15:0] blk_r0c1;
  logic [15:0] blk_r0c2;
  logic [15:0] blk_r1c0;
  logic [15:0] blk_r2c0;
  logic [15:0] blk_r1c1;
  logic [15:0] blk_r2c2;
  logic [15:0] blk_r1c2;
  logic [15:0] blk_r2c1;
  logic [15:0] tinted_pixel;

  modport source (
    output valid, blk_r0c0, blk_r0c1, blk_r0c2, blk_r1c0, blk_r2c0,
           blk_r1c1, blk_r2c2, blk_r1c2, blk_r2c1, tinted_pixel,
    input  ready
  );
  modport sink (
    input  valid, blk_r0c0, blk_r0c1, blk_r0c2, blk_r1c0, blk_r2c0,
           blk_r1c1, blk_r2c2, blk_r1c2, blk_r2c1, tinted_pixel,
    output ready
  );
endinterface

@@ hw/rtl/rzx3_blend.sv @@
// ----------------------------------------------------------------------------
// rzx3_blend
// One blended output pixel: (2*heavy + light)/3 per channel over two stages,
// replaced by the raw source word in nearest mode.
// ----------------------------------------------------------------------------
module rzx3_blend
  import rzx3_pkg::*;
(
  input  logic             clk,
  input  stage_en_t        en,
  input  rgb5_t            heavy_i,
  input  rgb5_t            light_i,
  input  logic             interp_s2_i,
  input  logic [PIX_W-1:0] src_s2_i,
  output logic [PIX_W-1:0] blk_o
);

  logic [SUM_W-1:0] sum_r_r, sum_g_r, sum_b_r;
  logic [SUM_W-1:0] sum_r_nxt, sum_g_nxt, sum_b_nxt;
  logic [PIX_W-1:0] blk_r, blk_nxt;
  rgb5_t            q;

  always_comb begin
    sum_r_nxt = {1'b0, heavy_i.r, 1'b0} + {2'b00, light_i.r};
    sum_g_nxt = {1'b0, heavy_i.g, 1'b0} + {2'b00, light_i.g};
    sum_b_nxt = {1'b0, heavy_i.b, 1'b0} + {2'b00, light_i.b};
  end

  always_comb begin
    q.r = div3(sum_r_r);
    q.g = div3(sum_g_r);
    q.b = div3(sum_b_r);
    blk_nxt = interp_s2_i ? pack5(q) : src_s2_i;
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      sum_r_r <= sum_r_nxt;
      sum_g_r <= sum_g_nxt;
      sum_b_r <= sum_b_nxt;
    end
    if (en.en3) begin
      blk_r <= blk_nxt;
    end
  end

  assign blk_o = blk_r;

endmodule

@@ hw/rtl/rgb555_zoom_x3_interpolate_core.sv @@
// ----------------------------------------------------------------------------
// rgb555_zoom_x3_interpolate_core
// Zooms one rgb555 pixel into a 3x3 block with per-channel blends toward its
// neighbours, and gives a tinted grey copy of the source pixel.
// ----------------------------------------------------------------------------
// pipeline: three register stages (1, 2, 3); an accepted item passes through
//   them in order and out valid is raised from stage 3
// throughput: one item per cycle unless out_ch stalls; each stage advances when
//   the next is empty or moving, so a full pipeline streams at one per clock
// reset: synchronous active-low rst_n empties all stages; payload is not reset
module rgb555_zoom_x3_interpolate_core
  import rzx3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rzx3_in_if.sink           in_ch,
  rzx3_out_if.source        out_ch
);

  logic      v1_r, v2_r, v3_r;
  logic      en1;
  stage_en_t en;

  // stage 1: neighbour masking and divider override
  rgb5_t            p1_r, p2_r, p3_r, p4_r;
  rgb5_t            p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic [PIX_W-1:0] src1_r;
  logic             interp1_r;
  logic [SUM_W-1:0] tsum_r, tsum_nxt;

  // stage 2
  logic [PIX_W-1:0] src2_r;
  logic             interp2_r;
  rgb5_t            corner2_r;
  logic [CH_W-1:0]  grey_r, grey_nxt;
  logic [CH_W:0]    grey_wide;

  // stage 3
  logic [PIX_W-1:0] corner3_r, corner3_nxt;
  logic [PIX_W-1:0] tint3_r, tint3_nxt;
  logic [PIX_W-1:0] blk [8];

  assign en.en3 = !v3_r || out_ch.ready;
  assign en.en2 = !v2_r || en.en3;
  assign en1    = !v1_r || en.en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1)    v1_r <= in_ch.valid;
      if (en.en2) v2_r <= v1_r;
      if (en.en3) v3_r <= v2_r;
    end
  end

  always_comb begin
    rgb5_t s;
    s      = rgb5_t'(in_ch.src_pixel[14:0]);
    p1_nxt = s;
    p2_nxt = in_ch.right_present ? rgb5_t'(in_ch.right_pixel[14:0]) : '0;
    p3_nxt = in_ch.below_present ? rgb5_t'(in_ch.below_pixel[14:0]) : '0;
    p4_nxt = (in_ch.right_present && in_ch.below_present) ?
             rgb5_t'(in_ch.diag_pixel[14:0]) : '0;
    if (in_ch.divider_mark) begin
      p1_nxt = DIV_COLOR;
      p2_nxt = DIV_COLOR;
      p3_nxt = DIV_COLOR;
      p4_nxt = DIV_COLOR;
    end
    tsum_nxt = {2'b00, s.r} + {2'b00, s.g} + {2'b00, s.b};
  end

  // tint level: average plus bias, saturated
  always_comb begin
    grey_wide = {1'b0, div3(tsum_r)} + {1'b0, GREY_BIAS};
    grey_nxt  = (grey_wide > {1'b0, GREY_MAX}) ? GREY_MAX : grey_wide[CH_W-1:0];
  end

  always_comb begin
    corner3_nxt = interp2_r ? pack5(corner2_r) : src2_r;
    tint3_nxt   = {TOP_BIT, grey_r, 2'b00, grey_r[CH_W-1:2], 1'b0, grey_r[CH_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      p3_r      <= p3_nxt;
      p4_r      <= p4_nxt;
      src1_r    <= in_ch.src_pixel;
      interp1_r <= in_ch.interp_mode;
      tsum_r    <= tsum_nxt;
    end
    if (en.en2) begin
      src2_r    <= src1_r;
      interp2_r <= interp1_r;
      corner2_r <= p1_r;
      grey_r    <= grey_nxt;
    end
    if (en.en3) begin
      corner3_r <= corner3_nxt;
      tint3_r   <= tint3_nxt;
    end
  end

  rzx3_blend u_r0c1 (.clk, .en, .heavy_i(p1_r), .light_i(p2_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[0]));
  rzx3_blend u_r0c2 (.clk, .en, .heavy_i(p2_r), .light_i(p1_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[1]));
  rzx3_blend u_r1c0 (.clk, .en, .heavy_i(p1_r), .light_i(p3_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[2]));
  rzx3_blend u_r2c0 (.clk, .en, .heavy_i(p3_r), .light_i(p1_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[3]));
  rzx3_blend u_r1c1 (.clk, .en, .heavy_i(p1_r), .light_i(p4_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[4]));
  rzx3_blend u_r2c2 (.clk, .en, .heavy_i(p4_r), .light_i(p1_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[5]));
  rzx3_blend u_r1c2 (.clk, .en, .heavy_i(p2_r), .light_i(p3_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[6]));
  rzx3_blend u_r2c1 (.clk, .en, .heavy_i(p3_r), .light_i(p2_r),
    .interp_s2_i(interp2_r), .src_s2_i(src2_r), .blk_o(blk[7]));

  assign out_ch.valid        = v3_r;
  assign out_ch.blk_r0c0     = corner3_r;
  assign out_ch.blk_r0c1     = blk[0];
  assign out_ch.blk_r0c2     = blk[1];
  assign out_ch.blk_r1c0     = blk[2];
  assign out_ch.blk_r2c0     = blk[3];
  assign out_ch.blk_r1c1     = blk[4];
  assign out_ch.blk_r2c2     = blk[5];
  assign out_ch.blk_r1c2     = blk[6];
  assign out_ch.blk_r2c1     = blk[7];
  assign out_ch.tinted_pixel = tint3_r;

  // input only stalls when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with an empty stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted item missing from stage 1");

  // an item in the last stage leaves only through the output handshake
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ch.ready) |=> (v3_r && $stable(tint3_r)))
    else $error("stalled item lost or changed");

  a_tint_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.tinted_pixel[15])
    else $error("tinted pixel without top bit");

endmodule

@@ dv/rgb555_zoom_x3_interpolate_core_tb.sv @@
// ----------------------------------------------------------------------------
// rgb555_zoom_x3_interpolate_core_tb
// Streams source pixels with their neighbours through the 3x zoom core and
// checks every result against an in-bench predictor. The predictor covers the
// blended 3x3 block, nearest replication, edge handling and the grey tint.
// Both channels idle at random, and some stretches run back to back.
// ----------------------------------------------------------------------------
module rgb555_zoom_x3_interpolate_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rzx3_pkg::*;

  // positions of the result fields in a packed result
  localparam int F_R0C0 = 0;
  localparam int F_R0C1 = 1;
  localparam int F_R0C2 = 2;
  localparam int F_R1C0 = 3;
  localparam int F_R2C0 = 4;
  localparam int F_R1C1 = 5;
  localparam int F_R2C2 = 6;
  localparam int F_R1C2 = 7;
  localparam int F_R2C1 = 8;
  localparam int F_TINT = 9;
  localparam int N_FIELDS = 10;

  localparam int MAX_SHOWN = 10;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] right;
    logic [15:0] below;
    logic [15:0] diag;
    logic        right_present;
    logic        below_present;
    logic        interp;
    logic        divider;
  } zoom_req_t;

  typedef logic [N_FIELDS-1:0][15:0] zoom_res_t;

  logic clk;
  logic rst_n;

  rzx3_in_if  in_ch ();
  rzx3_out_if out_ch ();

  rgb555_zoom_x3_interpolate_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  zoom_res_t expected_blocks[$];
  int failures        = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int interp_items    = 0;
  int divider_items   = 0;
  bit source_gaps     = 1'b0;
  bit sink_stalls     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d items sent, %0d results checked", items_sent, results_checked);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] pack_rgb(int red, int green, int blue);
    logic [4:0] r5, g5, b5;
    r5 = red[4:0];
    g5 = green[4:0];
    b5 = blue[4:0];
    return {1'b1, b5, g5, r5};
  endfunction

  // (2 heavy + light) / 3 on each channel, truncated
  function automatic logic [15:0] blend_thirds(rgb5_t heavy, rgb5_t light);
    return pack_rgb((2 * int'(heavy.r) + int'(light.r)) / 3,
                    (2 * int'(heavy.g) + int'(light.g)) / 3,
                    (2 * int'(heavy.b) + int'(light.b)) / 3);
  endfunction

  function automatic zoom_res_t predict_zoom(zoom_req_t q);
    zoom_res_t res;
    rgb5_t p_src, p_right, p_below, p_diag;
    int grey;
    if (q.interp) begin
      p_src   = q.src[14:0];
      p_right = q.right_present ? q.right[14:0] : 15'd0;
      p_below = q.below_present ? q.below[14:0] : 15'd0;
      p_diag  = (q.right_present && q.below_present) ? q.diag[14:0] : 15'd0;
      if (q.divider) begin
        p_src   = DIV_COLOR;
        p_right = DIV_COLOR;
        p_below = DIV_COLOR;
        p_diag  = DIV_COLOR;
      end
      res[F_R0C0] = {1'b1, p_src};
      res[F_R0C1] = blend_thirds(p_src, p_right);
      res[F_R0C2] = blend_thirds(p_right, p_src);
      res[F_R1C0] = blend_thirds(p_src, p_below);
      res[F_R2C0] = blend_thirds(p_below, p_src);
      res[F_R1C1] = blend_thirds(p_src, p_diag);
      res[F_R2C2] = blend_thirds(p_diag, p_src);
      res[F_R1C2] = blend_thirds(p_right, p_below);
      res[F_R2C1] = blend_thirds(p_below, p_right);
    end else begin
      for (int k = F_R0C0; k <= F_R2C1; k++) res[k] = q.src;
    end
    // tint always works on the raw source channels
    grey = (int'(q.src[4:0]) + int'(q.src[9:5]) + int'(q.src[14:10])) / 3 + 3;
    if (grey > 31) grey = 31;
    res[F_TINT] = pack_rgb(grey >> 1, grey >> 2, grey);
    return res;
  endfunction

  function automatic string field_label(int k);
    case (k)
      F_R0C0:  return "blk_r0c0";
      F_R0C1:  return "blk_r0c1";
      F_R0C2:  return "blk_r0c2";
      F_R1C0:  return "blk_r1c0";
      F_R2C0:  return "blk_r2c0";
      F_R1C1:  return "blk_r1c1";
      F_R2C2:  return "blk_r2c2";
      F_R1C2:  return "blk_r1c2";
      F_R2C1:  return "blk_r2c1";
      default: return "tinted_pixel";
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic zoom_req_t make_req(logic [15:0] src, logic [15:0] right,
                                         logic [15:0] below, logic [15:0] diag,
                                         logic rp, logic bp, logic interp,
                                         logic divider);
    zoom_req_t q;
    q.src           = src;
    q.right         = right;
    q.below         = below;
    q.diag          = diag;
    q.right_present = rp;
    q.below_present = bp;
    q.interp        = interp;
    q.divider       = divider;
    return q;
  endfunction

  // mostly short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // channels lean toward 0 and 31 so the blends hit their ends often
  function automatic logic [4:0] random_channel();
    case ($urandom_range(0, 3))
      0:       return 5'd0;
      1:       return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [15:0] random_pixel();
    logic [15:0] word;
    word = 16'($urandom());
    if ($urandom_range(0, 3) != 0)
      word = {1'($urandom_range(0, 1)), random_channel(), random_channel(),
              random_channel()};
    return word;
  endfunction

  function automatic zoom_req_t random_req();
    return make_req(random_pixel(), random_pixel(), random_pixel(), random_pixel(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
  endfunction

  task automatic drive_payload(input zoom_req_t q);
    in_ch.src_pixel     <= q.src;
    in_ch.right_pixel   <= q.right;
    in_ch.below_pixel   <= q.below;
    in_ch.diag_pixel    <= q.diag;
    in_ch.right_present <= q.right_present;
    in_ch.below_present <= q.below_present;
    in_ch.interp_mode   <= q.interp;
    in_ch.divider_mark  <= q.divider;
  endtask

  task automatic send_zoom(input zoom_req_t q);
    int gap;
    gap = (source_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      drive_payload(random_req());  // junk on the bus while idle
      repeat (gap) @(negedge clk);
    end
    drive_payload(q);
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_blocks.push_back(predict_zoom(q));
    items_sent++;
    if (q.interp) interp_items++;
    if (q.interp && q.divider) divider_items++;
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    zoom_res_t got;
    zoom_res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got[F_R0C0] = out_ch.blk_r0c0;
      got[F_R0C1] = out_ch.blk_r0c1;
      got[F_R0C2] = out_ch.blk_r0c2;
      got[F_R1C0] = out_ch.blk_r1c0;
      got[F_R2C0] = out_ch.blk_r2c0;
      got[F_R1C1] = out_ch.blk_r1c1;
      got[F_R2C2] = out_ch.blk_r2c2;
      got[F_R1C2] = out_ch.blk_r1c2;
      got[F_R2C1] = out_ch.blk_r2c1;
      got[F_TINT] = out_ch.tinted_pixel;
      if (expected_blocks.size() == 0) begin
        if (failures < MAX_SHOWN)
          $display("%0t: result with no item outstanding, r0c0 %h", $realtime, got[F_R0C0]);
        failures++;
      end else begin
        want = expected_blocks.pop_front();
        for (int k = 0; k < N_FIELDS; k++) begin
          if (got[k] !== want[k]) begin
            if (failures < MAX_SHOWN)
              $display("%0t: result %0d %s expected %h got %h", $realtime,
                       results_checked, field_label(k), want[k], got[k]);
            failures++;
          end
        end
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_extremes();
    send_zoom(make_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, 1, 0));
    send_zoom(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 0));
    send_zoom(make_req(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1, 1, 1, 0));
    send_zoom(make_req(16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1, 1, 0));
    // one channel per neighbour shows up the channel ordering
    send_zoom(make_req(16'h001F, 16'h03E0, 16'h7C00, 16'h5555, 1, 1, 1, 0));
    // small values check truncation of the thirds
    send_zoom(make_req(16'h0421, 16'h0842, 16'h0000, 16'h0C63, 1, 1, 1, 0));
  endtask

  task automatic test_missing_neighbours();
    send_zoom(make_req(16'h2D6B, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 1, 0));
    send_zoom(make_req(16'h2D6B, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 1, 0));
    send_zoom(make_req(16'h2D6B, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 1, 1, 0));
    send_zoom(make_req(16'h2D6B, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1, 1, 0));
  endtask

  task automatic test_divider();
    send_zoom(make_req(16'h7FFF, 16'h1234, 16'h4321, 16'hFFFF, 0, 0, 1, 1));
    send_zoom(make_req(16'hFFFF, 16'h1234, 16'h4321, 16'hFFFF, 1, 1, 1, 1));
    send_zoom(make_req(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1, 0, 1, 1));
    // divider means nothing in nearest mode
    send_zoom(make_req(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 1));
  endtask

  task automatic test_nearest();
    send_zoom(make_req(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0));
    send_zoom(make_req(16'h8001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 1, 0, 0));
    send_zoom(make_req(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000, 1, 0, 0, 0));
  endtask

  task automatic test_tint_saturation();
    // averages 27, 28 and 29 step across the clamp at 31
    send_zoom(make_req({1'b0, 5'd27, 5'd27, 5'd27}, 16'h0, 16'h0, 16'h0, 0, 0, 1, 0));
    send_zoom(make_req({1'b0, 5'd28, 5'd28, 5'd28}, 16'h0, 16'h0, 16'h0, 0, 0, 1, 0));
    send_zoom(make_req({1'b1, 5'd29, 5'd29, 5'd29}, 16'h0, 16'h0, 16'h0, 0, 0, 0, 0));
    send_zoom(make_req({1'b0, 5'd31, 5'd0, 5'd2}, 16'h0, 16'h0, 16'h0, 1, 1, 1, 0));
  endtask

  task automatic test_random_stream(input int count, input bit with_gaps);
    source_gaps = with_gaps;
    sink_stalls = with_gaps;
    repeat (count) send_zoom(random_req());
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_blocks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    drive_payload(make_req(16'h0, 16'h0, 16'h0, 16'h0, 0, 0, 0, 0));
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_missing_neighbours();
    test_divider();
    test_nearest();
    test_tint_saturation();
    test_random_stream(60, 1'b0);
    test_random_stream(390, 1'b1);
    drain_results();

    if (expected_blocks.size() != 0) begin
      $display("%0d expected results never arrived", expected_blocks.size());
      failures += expected_blocks.size();
    end
    $display("sent %0d items (%0d interpolated, %0d with divider), checked %0d results",
             items_sent, interp_items, divider_items, results_checked);
    $display("edge flags, nearest mode and tint clamp included; %0d mismatches", failures);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rzx3_pkg.sv
hw/rtl/rzx3_in_if.sv
hw/rtl/rzx3_out_if.sv
hw/rtl/rzx3_blend.sv
hw/rtl/rgb555_zoom_x3_interpolate_core.sv
dv/rgb555_zoom_x3_interpolate_core_tb.sv
